/* sv/shc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shc_pkg: shared types and constants of the strip hit clusterer
// Word layouts, register indexes, sequencer states and the structs that run
// between the sequencer, the accumulator and the serial divider.
// ----------------------------------------------------------------------------
package shc_pkg;

	localparam int unsigned NUM_STRIPS_DEF = 1024;

	localparam int CHAN_W     = 10;
	localparam int CHARGE_W   = 16;
	localparam int POS_W      = 20;
	localparam int IDX_W      = 11;
	localparam int SIZE_W     = 11;
	localparam int SUM_W      = 26;
	localparam int WSUM_W     = 46;
	localparam int GAP_W      = 4;
	localparam int PROD_W     = CHARGE_W + 1 + POS_W;
	localparam int QUOT_W     = POS_W;
	localparam int STEP_W     = $clog2(QUOT_W);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAP       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd2;

	localparam logic [SIZE_W-1:0] SIZE_MAX = '1;
	localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
	localparam logic signed [WSUM_W-1:0] WSUM_MAX = {1'b0, {(WSUM_W-1){1'b1}}};
	localparam logic signed [WSUM_W-1:0] WSUM_MIN = {1'b1, {(WSUM_W-1){1'b0}}};
	localparam logic signed [POS_W-1:0]  POS_MAX  = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0]  POS_MIN  = {1'b1, {(POS_W-1){1'b0}}};

	typedef struct packed {
		logic                     view;
		logic [CHAN_W-1:0]        strip_channel;
		logic [CHARGE_W-1:0]      strip_charge;
		logic signed [POS_W-1:0]  strip_position;
		logic                     event_end;
	} in_word_t;

	typedef struct packed {
		logic [IDX_W-1:0]         cluster_index;
		logic                     cluster_view;
		logic [CHAN_W-1:0]        seed_channel;
		logic [SIZE_W-1:0]        cluster_size;
		logic [SUM_W-1:0]         total_charge;
		logic signed [POS_W-1:0]  centroid;
		logic                     last_of_event;
	} out_word_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_EMIT,
		S_DIVW,
		S_OUTW,
		S_HIT,
		S_ADD,
		S_POST
	} state_t;

	typedef enum logic {
		AFTER_HIT,
		AFTER_END
	} after_t;

	typedef struct packed {
		logic                     start;
		logic signed [WSUM_W-1:0] num;
		logic [SUM_W-1:0]         den;
	} div_cmd_t;

	typedef struct packed {
		logic                     busy;
		logic signed [QUOT_W-1:0] quot;
	} div_stat_t;

	typedef struct packed {
		logic                     add;
		logic                     start;
		logic [CHARGE_W-1:0]      charge;
		logic signed [POS_W-1:0]  pos;
	} acc_cmd_t;

	typedef struct packed {
		logic [SIZE_W-1:0]        count;
		logic [SUM_W-1:0]         charge_sum;
		logic signed [WSUM_W-1:0] wsum;
	} acc_stat_t;

endpackage

/* sv/shc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shc_div: serial centroid divider
// Shift-subtract division of the weighted sum magnitude by the charge sum,
// one quotient bit per cycle, top bit first; the top bit flags a clamp.
// ----------------------------------------------------------------------------
module shc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  shc_pkg::div_cmd_t   cmd,
	output shc_pkg::div_stat_t  stat
);

	logic [shc_pkg::WSUM_W-1:0]   num_u;
	logic [shc_pkg::WSUM_W-1:0]   mag;
	logic [shc_pkg::WSUM_W-1:0]   rem_q;
	logic [shc_pkg::WSUM_W-1:0]   den_q;
	logic [shc_pkg::WSUM_W:0]     diff;
	logic                         ge;
	logic [shc_pkg::QUOT_W-1:0]   qbits_q;
	logic [shc_pkg::STEP_W-1:0]   step_q;
	logic                         busy_q;
	logic                         neg_q;
	logic                         zero_q;
	logic signed [shc_pkg::QUOT_W-1:0] qmag;

	assign num_u = cmd.num;
	assign mag   = num_u[shc_pkg::WSUM_W-1] ? (~num_u + 1'b1) : num_u;
	assign diff  = {1'b0, rem_q} - {1'b0, den_q};
	assign ge    = !diff[shc_pkg::WSUM_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			step_q <= shc_pkg::STEP_W'(shc_pkg::QUOT_W - 1);
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
			end
			step_q <= step_q - 1'b1;
		end
	end

	// divisor starts aligned to the clamp bit and walks down one place a cycle
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q   <= mag;
			den_q   <= shc_pkg::WSUM_W'({cmd.den, {(shc_pkg::QUOT_W-1){1'b0}}});
			qbits_q <= '0;
			neg_q   <= cmd.num[shc_pkg::WSUM_W-1];
			zero_q  <= (cmd.den == '0);
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= diff[shc_pkg::WSUM_W-1:0];
			end
			qbits_q <= {qbits_q[shc_pkg::QUOT_W-2:0], ge};
			den_q   <= den_q >> 1;
		end
	end

	assign qmag = $signed({1'b0, qbits_q[shc_pkg::QUOT_W-2:0]});

	always_comb begin
		stat.busy = busy_q;
		if (zero_q) begin
			stat.quot = '0;
		end else if (qbits_q[shc_pkg::QUOT_W-1]) begin
			stat.quot = neg_q ? shc_pkg::POS_MIN : shc_pkg::POS_MAX;
		end else begin
			stat.quot = neg_q ? -qmag : qmag;
		end
	end

endmodule

/* sv/shc_accum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shc_accum: cluster accumulator
// Registered charge-times-position product, then saturating updates of the
// hit count, charge sum and weighted position sum.
// ----------------------------------------------------------------------------
module shc_accum (
	input  logic                clk,
	input  logic                arst_n,
	input  shc_pkg::acc_cmd_t   cmd,
	output shc_pkg::acc_stat_t  stat
);

	logic signed [shc_pkg::PROD_W-1:0] prod;
	logic signed [shc_pkg::PROD_W-1:0] prod_s1;
	logic [shc_pkg::CHARGE_W-1:0]      charge_s1;
	logic                              valid_s1;
	logic                              start_s1;

	logic [shc_pkg::SIZE_W-1:0]        count_q;
	logic [shc_pkg::SUM_W-1:0]         charge_q;
	logic signed [shc_pkg::WSUM_W-1:0] wsum_q;

	logic [shc_pkg::SIZE_W-1:0]        base_count;
	logic [shc_pkg::SUM_W-1:0]         base_charge;
	logic signed [shc_pkg::WSUM_W-1:0] base_wsum;
	logic [shc_pkg::SUM_W:0]           charge_add;
	logic [shc_pkg::WSUM_W:0]          wsum_add;
	logic [shc_pkg::SIZE_W-1:0]        count_nx;
	logic [shc_pkg::SUM_W-1:0]         charge_nx;
	logic signed [shc_pkg::WSUM_W-1:0] wsum_nx;

	assign prod = $signed({1'b0, cmd.charge}) * cmd.pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.add;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add) begin
			prod_s1   <= prod;
			charge_s1 <= cmd.charge;
			start_s1  <= cmd.start;
		end
	end

	always_comb begin
		base_count  = start_s1 ? '0 : count_q;
		base_charge = start_s1 ? '0 : charge_q;
		base_wsum   = start_s1 ? '0 : wsum_q;

		count_nx = (base_count == shc_pkg::SIZE_MAX) ? base_count : base_count + 1'b1;

		charge_add = {1'b0, base_charge} + (shc_pkg::SUM_W+1)'(charge_s1);
		charge_nx  = charge_add[shc_pkg::SUM_W] ? shc_pkg::SUM_MAX
		                                        : charge_add[shc_pkg::SUM_W-1:0];

		wsum_add = {base_wsum[shc_pkg::WSUM_W-1], base_wsum} + (shc_pkg::WSUM_W+1)'(prod_s1);
		if (wsum_add[shc_pkg::WSUM_W] != wsum_add[shc_pkg::WSUM_W-1]) begin
			wsum_nx = wsum_add[shc_pkg::WSUM_W] ? shc_pkg::WSUM_MIN : shc_pkg::WSUM_MAX;
		end else begin
			wsum_nx = wsum_add[shc_pkg::WSUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			charge_q <= '0;
			wsum_q   <= '0;
		end else if (valid_s1) begin
			count_q  <= count_nx;
			charge_q <= charge_nx;
			wsum_q   <= wsum_nx;
		end
	end

	assign stat.count      = count_q;
	assign stat.charge_sum = charge_q;
	assign stat.wsum       = wsum_q;

endmodule

/* sv/strip_hit_clusterer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strip_hit_clusterer: charge-centroid cluster finder for strip readings
// Groups threshold-passing strips into clusters of neighbouring channels and
// emits each closed cluster with its size, total charge and centroid.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              word
//  in        input      in_valid / in_stall    shc_pkg::in_word_t
//  out       output     out_valid / out_stall  shc_pkg::out_word_t
//  cfg       input      cfg_we                 cfg_index, cfg_data
//
//  A strip word is taken in the idle state; in_stall stays high until it is
//  done: S_EVAL for a non-hit, then S_HIT, S_ADD and S_POST for a hit, plus
//  for each cluster it closes S_EMIT (divider start), S_DIVW (the serial
//  divider steps until it is seen to finish) and S_OUTW (the hand-off).
//  The output register frees the block while a word waits; a stalled output
//  holds the sequencer only when the next cluster is ready to hand off.
//  Reset clears the cluster state and sets enable; no clearing pass.
// ----------------------------------------------------------------------------
module strip_hit_clusterer #(
	parameter int unsigned NUM_STRIPS = shc_pkg::NUM_STRIPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  shc_pkg::in_word_t                 in_word,
	output logic                              out_valid,
	input  logic                              out_stall,
	output shc_pkg::out_word_t                out_word,
	input  logic                              cfg_we,
	input  logic [shc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [shc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	shc_pkg::state_t   state_q;
	shc_pkg::state_t   state_nx;
	shc_pkg::after_t   after_q;
	shc_pkg::in_word_t item_q;
	shc_pkg::out_word_t pend_q;
	shc_pkg::out_word_t out_word_q;
	shc_pkg::div_cmd_t  div_cmd;
	shc_pkg::div_stat_t div_stat;
	shc_pkg::acc_cmd_t  acc_cmd;
	shc_pkg::acc_stat_t acc_stat;

	logic [shc_pkg::CHARGE_W-1:0] thr_q;
	logic [shc_pkg::GAP_W-1:0]    gap_q;
	logic                         en_q;

	logic                         open_q;
	logic [shc_pkg::IDX_W-1:0]    counter_q;
	logic                         prev_view_q;
	logic [shc_pkg::CHAN_W-1:0]   prev_chan_q;
	logic [shc_pkg::CHAN_W-1:0]   seed_q;
	logic                         joins_q;
	logic                         last_q;
	logic                         out_valid_q;

	logic                         hit;
	logic                         joins;
	logic [shc_pkg::CHAN_W-1:0]   chan_delta;
	logic                         load_out;
	logic                         clr_evt;

	shc_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (acc_cmd),
		.stat   (acc_stat)
	);

	shc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.stat   (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
			gap_q <= '0;
			en_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				shc_pkg::REG_THRESHOLD: thr_q <= cfg_data;
				shc_pkg::REG_GAP:       gap_q <= cfg_data[shc_pkg::GAP_W-1:0];
				shc_pkg::REG_ENABLE:    en_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// hit and neighbour decode of the held strip
	always_comb begin
		chan_delta = (item_q.strip_channel > prev_chan_q) ? item_q.strip_channel - prev_chan_q
		                                                  : prev_chan_q - item_q.strip_channel;
		hit = (item_q.strip_charge > thr_q) && (32'(item_q.strip_channel) < NUM_STRIPS);
		joins = open_q && (item_q.view == prev_view_q) &&
		        ({1'b0, chan_delta} == (shc_pkg::CHAN_W+1)'(gap_q) + (shc_pkg::CHAN_W+1)'(1));
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			shc_pkg::S_IDLE: begin
				if (in_valid) begin
					state_nx = shc_pkg::S_EVAL;
				end
			end
			shc_pkg::S_EVAL: begin
				if (!en_q) begin
					state_nx = shc_pkg::S_IDLE;
				end else if (hit && !joins && open_q) begin
					state_nx = shc_pkg::S_EMIT;
				end else if (hit) begin
					state_nx = shc_pkg::S_HIT;
				end else if (item_q.event_end && open_q) begin
					state_nx = shc_pkg::S_EMIT;
				end else begin
					state_nx = shc_pkg::S_IDLE;
				end
			end
			shc_pkg::S_EMIT: state_nx = shc_pkg::S_DIVW;
			shc_pkg::S_DIVW: begin
				if (!div_stat.busy) begin
					state_nx = shc_pkg::S_OUTW;
				end
			end
			shc_pkg::S_OUTW: begin
				if (!out_valid_q || !out_stall) begin
					state_nx = (after_q == shc_pkg::AFTER_HIT) ? shc_pkg::S_HIT : shc_pkg::S_IDLE;
				end
			end
			shc_pkg::S_HIT:  state_nx = shc_pkg::S_ADD;
			shc_pkg::S_ADD:  state_nx = shc_pkg::S_POST;
			shc_pkg::S_POST: begin
				state_nx = item_q.event_end ? shc_pkg::S_EMIT : shc_pkg::S_IDLE;
			end
			default: state_nx = shc_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_stall       = (state_q != shc_pkg::S_IDLE);
		div_cmd.start  = (state_q == shc_pkg::S_EMIT);
		div_cmd.num    = acc_stat.wsum;
		div_cmd.den    = acc_stat.charge_sum;
		acc_cmd.add    = (state_q == shc_pkg::S_HIT);
		acc_cmd.start  = !joins_q;
		acc_cmd.charge = item_q.strip_charge;
		acc_cmd.pos    = item_q.strip_position;
		load_out       = (state_q == shc_pkg::S_OUTW) && (!out_valid_q || !out_stall);
		clr_evt        = 1'b0;
		unique case (state_q)
			shc_pkg::S_EVAL: clr_evt = !en_q || (!hit && item_q.event_end && !open_q);
			shc_pkg::S_OUTW: clr_evt = load_out && (after_q == shc_pkg::AFTER_END);
			default:         clr_evt = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= shc_pkg::S_IDLE;
			after_q     <= shc_pkg::AFTER_END;
			open_q      <= 1'b0;
			counter_q   <= '0;
			prev_view_q <= 1'b0;
			prev_chan_q <= '0;
			seed_q      <= '0;
			joins_q     <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;

			if (state_q == shc_pkg::S_EVAL) begin
				joins_q <= joins;
				last_q  <= !(hit && !joins && open_q);
				after_q <= (hit && !joins && open_q) ? shc_pkg::AFTER_HIT : shc_pkg::AFTER_END;
			end
			if (state_q == shc_pkg::S_POST) begin
				last_q  <= 1'b1;
				after_q <= shc_pkg::AFTER_END;
			end

			if (state_q == shc_pkg::S_HIT) begin
				if (!joins_q) begin
					open_q <= 1'b1;
					seed_q <= item_q.strip_channel;
				end
				prev_view_q <= item_q.view;
				prev_chan_q <= item_q.strip_channel;
			end

			// advance the index per emitted cluster, drop it at event end or when disabled
			if (clr_evt) begin
				open_q    <= 1'b0;
				counter_q <= '0;
			end else if (state_q == shc_pkg::S_EMIT) begin
				counter_q <= counter_q + 1'b1;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_q <= in_word;
		end
		if (state_q == shc_pkg::S_EMIT) begin
			pend_q.cluster_index <= counter_q;
			pend_q.cluster_view  <= prev_view_q;
			pend_q.seed_channel  <= seed_q;
			pend_q.cluster_size  <= acc_stat.count;
			pend_q.total_charge  <= acc_stat.charge_sum;
			pend_q.centroid      <= '0;
			pend_q.last_of_event <= last_q;
		end
		if (load_out) begin
			out_word_q          <= pend_q;
			out_word_q.centroid <= div_stat.quot;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	a_div_idle_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == shc_pkg::S_EMIT) |-> !div_stat.busy)
		else $error("divider started while still busy");

	a_hit_committed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == shc_pkg::S_POST) |-> (acc_stat.count != '0) && open_q)
		else $error("hit not committed before event end check");

	a_event_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && pend_q.last_of_event) |=> (counter_q == '0) && !open_q)
		else $error("event end cluster left state behind");

endmodule
